### rtl/per_source_packet_counter_assert.svh
// ----------------------------------------------------------------------------
// per_source_packet_counter_assert.svh
// Assertion macros used by the packet counter RTL.
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_PACKET_COUNTER_ASSERT_SVH
`define PER_SOURCE_PACKET_COUNTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PSPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pspc assertion failed");

// next-cycle implication, checked out of reset
`define PSPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pspc assertion failed");

`endif

### rtl/pspc_pkg.sv
// ----------------------------------------------------------------------------
// pspc_pkg
// Sizes, types and constants of the per-source packet counter.
// ----------------------------------------------------------------------------
package pspc_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int COUNT_WIDTH = 32;
  localparam int IP_W        = 32;
  localparam int SLOT_W      = 7;
  localparam int PKT_CNT_W   = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 40;
  localparam int OUT_USER_W  = 2;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [USED_W-1:0]      used_t;
  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [IP_W-1:0]        ip_t;

  localparam cnt_t  CNT_MAX   = '1;
  localparam used_t USED_FULL = USED_W'(TABLE_DEPTH);
  localparam idx_t  LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);

  // search outcome, valid while done is high
  typedef struct packed {
    logic done;
    logic hit;
    idx_t idx;
    cnt_t cnt;
  } srch_rsp_t;

  // table write port
  typedef struct packed {
    logic en;
    logic addr_en;
    idx_t idx;
    ip_t  addr;
    cnt_t cnt;
  } tbl_wr_t;

endpackage

### rtl/pspc_table.sv
// ----------------------------------------------------------------------------
// pspc_table
// Address and count memories with a pipelined linear search, one entry a
// cycle, lowest slot first.
// ----------------------------------------------------------------------------
module pspc_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pspc_pkg::ip_t       key_i,
  input  pspc_pkg::used_t     used_i,
  input  pspc_pkg::tbl_wr_t   wr_i,
  output pspc_pkg::srch_rsp_t rsp_o
);
  import pspc_pkg::*;

  ip_t   addr_mem [TABLE_DEPTH];
  cnt_t  cnt_mem  [TABLE_DEPTH];

  logic  busy_q, busy_d;
  ip_t   key_q;
  used_t iss_q, iss_d;
  logic  rd_vld_q;
  idx_t  rd_idx_q;
  ip_t   addr_rd_q;
  cnt_t  cnt_rd_q;

  logic  hit_now;
  logic  issue;
  logic  done;
  idx_t  rd_a;

  assign rd_a    = iss_q[IDX_W-1:0];
  assign hit_now = busy_q && rd_vld_q && (addr_rd_q == key_q);
  assign done    = busy_q && (hit_now || (iss_q == used_i));
  assign issue   = busy_q && !done;

  always_comb begin
    busy_d = busy_q;
    iss_d  = iss_q;
    if (start_i) begin
      busy_d = 1'b1;
      iss_d  = '0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (issue) begin
      iss_d = iss_q + used_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      iss_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      iss_q    <= iss_d;
      rd_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end
    rd_idx_q <= rd_a;
  end

  // memories: one read and one write port each
  always_ff @(posedge clk_i) begin
    addr_rd_q <= addr_mem[rd_a];
    cnt_rd_q  <= cnt_mem[rd_a];
    if (wr_i.en) begin
      cnt_mem[wr_i.idx] <= wr_i.cnt;
      if (wr_i.addr_en) begin
        addr_mem[wr_i.idx] <= wr_i.addr;
      end
    end
  end

  assign rsp_o.done = done;
  assign rsp_o.hit  = hit_now;
  assign rsp_o.idx  = rd_idx_q;
  assign rsp_o.cnt  = cnt_rd_q;

endmodule

### rtl/per_source_packet_counter.sv
// ----------------------------------------------------------------------------
// per_source_packet_counter
// Counts packets per IPv4 source address in a table searched in insertion
// order; appends unseen addresses and overwrites the last slot when full.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (lsb first)           tuser (lsb first)
//  s_axis   in   src_addr[31:0]              -
//  m_axis   out  slot[6:0], pkt_count[31:0]  is_new, overflow
//
// A word's search reads the occupied slots in turn through the address
// memory read port and compares each with the key, then the update
// writes the slot and loads the result. A hit ends the search early.
// The next word is taken once the block is back in idle. Reset leaves
// the table empty; no clearing pass. A stalled result holds the update
// until the output register frees.
module per_source_packet_counter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [pspc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // src_addr
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [pspc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // slot, pkt_count
  output logic [pspc_pkg::OUT_USER_W-1:0]    m_axis_tuser   // is_new, overflow
);
  import pspc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_e;

  state_e    state_q;
  ip_t       key_q;
  logic      hit_q;
  idx_t      slot_q;
  cnt_t      cnt_q;
  used_t     used_q;

  logic      out_vld_q;
  idx_t      out_slot_q;
  cnt_t      out_cnt_q;
  logic      out_new_q;
  logic      out_ovf_q;

  logic      accept;
  logic      full;
  logic      load_ok;
  cnt_t      new_cnt;
  srch_rsp_t rsp;
  tbl_wr_t   wr;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (used_q == USED_FULL);
  assign load_ok       = !out_vld_q || m_axis_tready;

  always_comb begin
    if (!hit_q) begin
      new_cnt = cnt_t'(1);
    end else if (cnt_q == CNT_MAX) begin
      new_cnt = cnt_q;
    end else begin
      new_cnt = cnt_q + cnt_t'(1);
    end
  end

  assign wr.en      = (state_q == ST_UPDATE) && load_ok;
  assign wr.addr_en = !hit_q;
  assign wr.idx     = slot_q;
  assign wr.addr    = key_q;
  assign wr.cnt     = new_cnt;

  pspc_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .key_i   (ip_t'(s_axis_tdata)),
    .used_i  (used_q),
    .wr_i    (wr),
    .rsp_o   (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && m_axis_tready && !wr.en) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (rsp.done) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (load_ok) begin
            out_vld_q <= 1'b1;
            if (!hit_q && !full) begin
              used_q <= used_q + used_t'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= ip_t'(s_axis_tdata);
    end
    if (state_q == ST_SEARCH && rsp.done) begin
      hit_q <= rsp.hit;
      cnt_q <= rsp.cnt;
      if (rsp.hit) begin
        slot_q <= rsp.idx;
      end else if (full) begin
        slot_q <= LAST_IDX;
      end else begin
        slot_q <= used_q[IDX_W-1:0];
      end
    end
    if (wr.en) begin
      out_slot_q <= slot_q;
      out_cnt_q  <= new_cnt;
      out_new_q  <= !hit_q;
      out_ovf_q  <= !hit_q && full;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, PKT_CNT_W'(out_cnt_q), SLOT_W'(out_slot_q)};
  assign m_axis_tuser  = {out_ovf_q, out_new_q};

  `include "per_source_packet_counter_assert.svh"

  `PSPC_ASSERT_IMP(a_used_range, 1'b1, used_q <= USED_FULL)
  `PSPC_ASSERT_IMP(a_done_in_search, rsp.done, state_q == ST_SEARCH)
  `PSPC_ASSERT_IMP(a_ovf_is_new, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0])
  `PSPC_ASSERT_NXT(a_used_step, state_q != ST_UPDATE, used_q == $past(used_q))

endmodule
